// ===== hw/rtl/keyed_sum_table_linear_probe_core_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the keyed sum table core
// Implication checks sampled on clk, off while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef KEYED_SUM_TABLE_LINEAR_PROBE_CORE_MACROS_SVH
`define KEYED_SUM_TABLE_LINEAR_PROBE_CORE_MACROS_SVH

// Same-cycle implication.
`define KSTLP_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define KSTLP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/kstlp_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// kstlp_pkg
// Beat types and codes for the keyed sum table with linear probing.
// ---------------------------------------------------------------------------
package kstlp_pkg;

    localparam logic [1:0] ACT_ACCUM = 2'd0;
    localparam logic [1:0] ACT_READ  = 2'd1;
    localparam logic [1:0] ACT_CLEAR = 2'd2;

    localparam logic [2:0] STAT_UPDATED  = 3'd0;
    localparam logic [2:0] STAT_INSERTED = 3'd1;
    localparam logic [2:0] STAT_FULL     = 3'd2;
    localparam logic [2:0] STAT_READ     = 3'd3;
    localparam logic [2:0] STAT_CLEARED  = 3'd4;

    typedef struct packed {
        logic [1:0]  action;
        logic [31:0] key;
        logic [63:0] amount;
        logic [6:0]  slot_index;
    } req_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [6:0]  slot;
        logic        occupied;
        logic [31:0] slot_key;
        logic [63:0] slot_sum;
    } rsp_t;

    typedef struct packed {
        logic        valid;
        logic [31:0] key;
        logic [63:0] sum;
    } slot_word_t;

endpackage

// ===== hw/rtl/keyed_sum_table_linear_probe_core.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// keyed_sum_table_linear_probe_core
// Group-by-sum table, open addressing, linear probing, one slot memory.
// ---------------------------------------------------------------------------
//  channel | beat   | handshake            | carries
//  req     | req_t  | req_valid, req_stall | action, key, amount, slot_index
//  rsp     | rsp_t  | rsp_valid, rsp_stall | status, slot, occupied, key, sum
//
//  Accumulate: S_HASH, S_HOME, then S_PROBE over k slots (1..TABLE_SLOTS);
//  the slot memory gives one probe per cycle through its single read port.
//  Read: a registered slot read, then S_RDOUT. Clear: one slot written per
//  cycle. After reset a clearing pass over every slot runs; req_stall stays high.
//  A new item is taken while a result waits; a stalled rsp holds the core
//  only when the next result is ready.
// ---------------------------------------------------------------------------
`include "keyed_sum_table_linear_probe_core_macros.svh"

module keyed_sum_table_linear_probe_core #(
    parameter int TABLE_SLOTS = 128
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_stall,
    input  kstlp_pkg::req_t req,
    output logic            rsp_valid,
    input  logic            rsp_stall,
    output kstlp_pkg::rsp_t rsp
);
    import kstlp_pkg::*;

    localparam int AW = $clog2(TABLE_SLOTS);
    localparam int RW = AW + 1;
    localparam int XW = ((AW > 7) ? AW : 7) + 1;
    localparam logic [63:0] RECIP_FULL = 64'h1_0000_0000 / 64'(TABLE_SLOTS);
    localparam logic [31:0] RECIP = RECIP_FULL[31:0];
    localparam logic [AW-1:0] LAST_SLOT = AW'(TABLE_SLOTS - 1);

    localparam logic [2:0] S_INIT  = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_HASH  = 3'd2;
    localparam logic [2:0] S_HOME  = 3'd3;
    localparam logic [2:0] S_PROBE = 3'd4;
    localparam logic [2:0] S_RDOUT = 3'd5;
    localparam logic [2:0] S_CLEAR = 3'd6;

    slot_word_t mem [TABLE_SLOTS];
    slot_word_t rd_reg;

    logic [2:0]    state_reg, state_next;
    logic [AW-1:0] pos_reg, pos_next;
    logic [AW-1:0] cnt_reg, cnt_next;
    logic          in_range_reg, in_range_next;
    req_t          item_reg, item_next;
    logic [31:0]   q_reg, q_next;
    logic          out_valid_reg;
    rsp_t          out_reg;

    logic          accept;
    logic          out_free;
    logic          emit;
    rsp_t          res;
    logic          mem_we;
    slot_word_t    mem_wd;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] pos_inc;
    logic [63:0]   prod_full;
    logic [RW-1:0] prod_low;
    logic [RW-1:0] rem;
    logic [RW-1:0] home;
    logic [XW-1:0] idx_wide;
    logic          hit;
    logic          empty;
    logic          last_probe;
    logic [63:0]   sum_new;
    logic          occ;

    assign accept    = req_valid && !req_stall;
    assign req_stall = (state_reg != S_IDLE);
    assign out_free  = !out_valid_reg || !rsp_stall;
    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

    assign pos_inc    = (pos_reg == LAST_SLOT) ? '0 : pos_reg + 1'b1;
    assign prod_full  = 64'(item_reg.key) * 64'(RECIP);
    assign prod_low   = q_reg[RW-1:0] * RW'(TABLE_SLOTS);
    assign rem        = RW'(item_reg.key) - prod_low;
    assign home       = (rem >= RW'(TABLE_SLOTS)) ? rem - RW'(TABLE_SLOTS) : rem;
    assign idx_wide   = XW'(req.slot_index);
    assign empty      = !rd_reg.valid;
    assign hit        = rd_reg.valid && (rd_reg.key == item_reg.key);
    assign last_probe = (cnt_reg == LAST_SLOT);
    assign sum_new    = rd_reg.sum + item_reg.amount;
    assign occ        = in_range_reg && rd_reg.valid;

    always_comb
    begin
        state_next    = state_reg;
        pos_next      = pos_reg;
        cnt_next      = cnt_reg;
        in_range_next = in_range_reg;
        item_next     = item_reg;
        q_next        = q_reg;
        rd_addr       = pos_reg;
        mem_we        = 1'b0;
        mem_wd        = '0;
        emit          = 1'b0;
        res           = '0;

        case (state_reg)
            S_INIT:
            begin
                mem_we = 1'b1;
                if (pos_reg == LAST_SLOT)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    pos_next = pos_inc;
                end
            end
            S_IDLE:
            begin
                rd_addr = AW'(req.slot_index);
                if (accept)
                begin
                    item_next = req;
                    case (req.action)
                        ACT_ACCUM:
                        begin
                            state_next = S_HASH;
                        end
                        ACT_CLEAR:
                        begin
                            pos_next   = '0;
                            state_next = S_CLEAR;
                        end
                        ACT_READ:
                        begin
                            pos_next      = AW'(req.slot_index);
                            in_range_next = idx_wide < XW'(TABLE_SLOTS);
                            state_next    = S_RDOUT;
                        end
                        default:
                        begin
                            pos_next      = AW'(req.slot_index);
                            in_range_next = idx_wide < XW'(TABLE_SLOTS);
                            state_next    = S_RDOUT;
                        end
                    endcase
                end
            end
            S_HASH:
            begin
                q_next     = prod_full[63:32];
                state_next = S_HOME;
            end
            S_HOME:
            begin
                rd_addr    = AW'(home);
                pos_next   = AW'(home);
                cnt_next   = '0;
                state_next = S_PROBE;
            end
            S_PROBE:
            begin
                if (empty || hit || last_probe)
                begin
                    if (out_free)
                    begin
                        emit       = 1'b1;
                        state_next = S_IDLE;
                        if (empty)
                        begin
                            mem_we = 1'b1;
                            mem_wd = '{valid: 1'b1, key: item_reg.key, sum: item_reg.amount};
                            res    = '{status: STAT_INSERTED, slot: 7'(pos_reg),
                                       occupied: 1'b1, slot_key: item_reg.key,
                                       slot_sum: item_reg.amount};
                        end
                        else if (hit)
                        begin
                            mem_we = 1'b1;
                            mem_wd = '{valid: 1'b1, key: item_reg.key, sum: sum_new};
                            res    = '{status: STAT_UPDATED, slot: 7'(pos_reg),
                                       occupied: 1'b1, slot_key: item_reg.key,
                                       slot_sum: sum_new};
                        end
                        else
                        begin
                            res.status = STAT_FULL;
                        end
                    end
                end
                else
                begin
                    rd_addr  = pos_inc;
                    pos_next = pos_inc;
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_RDOUT:
            begin
                if (out_free)
                begin
                    emit       = 1'b1;
                    state_next = S_IDLE;
                    res        = '{status: STAT_READ, slot: item_reg.slot_index,
                                   occupied: occ,
                                   slot_key: occ ? rd_reg.key : 32'd0,
                                   slot_sum: occ ? rd_reg.sum : 64'd0};
                end
            end
            S_CLEAR:
            begin
                mem_we = 1'b1;
                if (pos_reg == LAST_SLOT)
                begin
                    if (out_free)
                    begin
                        emit       = 1'b1;
                        res.status = STAT_CLEARED;
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    pos_next = pos_inc;
                end
            end
            default:
            begin
                state_next = S_INIT;
                pos_next   = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[pos_reg] <= mem_wd;
        end
        rd_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            pos_reg       <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pos_reg   <= pos_next;
            cnt_reg   <= cnt_next;
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg     <= item_next;
        q_reg        <= q_next;
        in_range_reg <= in_range_next;
        if (emit)
        begin
            out_reg <= res;
        end
    end

    `KSTLP_ASSERT_SAME(a_probe_write_free, (state_reg == S_PROBE) && mem_we, out_free, "probe write without room for its result")
    `KSTLP_ASSERT_NEXT(a_accum_to_hash, accept && (req.action == ACT_ACCUM), state_reg == S_HASH, "accumulate beat did not start hashing")
    `KSTLP_ASSERT_SAME(a_full_zero, rsp_valid && (rsp.status == STAT_FULL), (rsp.slot == 7'd0) && !rsp.occupied, "full result carries a slot")
    `KSTLP_ASSERT_SAME(a_init_quiet, state_reg == S_INIT, !rsp_valid, "result during reset clearing pass")

endmodule
